/* sv/rfp_pkg.sv */
// Package with the types, codes and constants shared by the response frame parser.
package rfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER       = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_HUNT      = 4'd0,
        KIND_START_OK  = 4'd1,
        KIND_PERIPH_ID = 4'd2,
        KIND_META      = 4'd3,
        KIND_ERR_CODE  = 4'd4,
        KIND_DATA      = 4'd5,
        KIND_BAD_START = 4'd6,
        KIND_BAD_END   = 4'd7,
        KIND_FRAME_OK  = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SOM2 = 3'd1,
        PH_PID  = 3'd2,
        PH_META = 3'd3,
        PH_ERR  = 3'd4,
        PH_DATA = 3'd5,
        PH_END  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker_one;
        logic [BYTE_W-1:0] start_marker_two;
        logic [BYTE_W-1:0] end_marker;
    } t_markers;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] data_index;
        logic              frame_end;
    } t_result;

endpackage

/* sv/rfp_in_if.sv */
// Channel carrying received bytes into the parser.
interface rfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [7:0] expected_length;

    modport source (output valid, output rx_byte, output expected_length, input ready);
    modport sink   (input valid, input rx_byte, input expected_length, output ready);
endinterface

/* sv/rfp_out_if.sv */
// Channel carrying parse results out of the parser.
interface rfp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] value;
    logic [7:0] data_index;
    logic       frame_end;

    modport source (output valid, output kind, output value, output data_index,
                    output frame_end, input ready);
    modport sink   (input valid, input kind, input value, input data_index,
                    input frame_end, output ready);
endinterface

/* sv/rfp_cfg_regs.sv */
// Marker configuration registers written through the plain write port.
module rfp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfp_pkg::BYTE_W-1:0]     i_cfg_data,
    output rfp_pkg::t_markers              o_markers
);
    import rfp_pkg::*;

    t_markers r_markers;
    t_markers n_markers;

    always_comb begin
        n_markers = r_markers;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_MARKER_ONE: n_markers.start_marker_one = i_cfg_data;
                REG_START_MARKER_TWO: n_markers.start_marker_two = i_cfg_data;
                REG_END_MARKER:       n_markers.end_marker       = i_cfg_data;
                default:              n_markers = r_markers;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markers <= '0;
        end else begin
            r_markers <= n_markers;
        end
    end

    assign o_markers = r_markers;

endmodule

/* sv/rfp_parser.sv */
// Frame phase state machine that classifies each accepted byte.
module rfp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [rfp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [rfp_pkg::BYTE_W-1:0] i_expected_length,
    input  rfp_pkg::t_markers          i_markers,
    output rfp_pkg::t_result           o_result
);
    import rfp_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] n_len;
    logic [BYTE_W-1:0] r_cnt;
    logic [BYTE_W-1:0] n_cnt;
    logic [BYTE_W-1:0] cnt_inc;
    t_kind             kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    assign cnt_inc = r_cnt + 8'd1;

    always_comb begin
        n_phase             = r_phase;
        n_len               = r_len;
        n_cnt               = r_cnt;
        kind                = KIND_HUNT;
        o_result.data_index = '0;
        o_result.frame_end  = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == i_markers.start_marker_one) begin
                    kind    = KIND_START_OK;
                    n_len   = (i_expected_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                                : i_expected_length;
                    n_cnt   = '0;
                    n_phase = PH_SOM2;
                end else begin
                    kind = KIND_BAD_START;
                end
            end
            PH_SOM2: begin
                if (i_rx_byte == i_markers.start_marker_two) begin
                    kind    = KIND_START_OK;
                    n_phase = PH_PID;
                end else begin
                    kind               = KIND_BAD_START;
                    o_result.frame_end = 1'b1;
                    n_phase            = PH_HUNT;
                end
            end
            PH_PID: begin
                kind    = KIND_PERIPH_ID;
                n_phase = PH_META;
            end
            PH_META: begin
                kind    = KIND_META;
                n_phase = PH_ERR;
            end
            PH_ERR: begin
                kind    = KIND_ERR_CODE;
                n_cnt   = '0;
                n_phase = (r_len == '0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
                kind                = KIND_DATA;
                o_result.data_index = r_cnt;
                n_cnt               = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_END;
                end
            end
            default: begin
                kind               = (i_rx_byte == i_markers.end_marker) ? KIND_FRAME_OK
                                                                         : KIND_BAD_END;
                o_result.frame_end = 1'b1;
                n_phase            = PH_HUNT;
            end
        endcase
        o_result.kind  = kind;
        o_result.value = i_rx_byte;
    end

endmodule

/* sv/rfp_out_reg.sv */
// Result register that holds a beat until the downstream side takes it.
module rfp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rfp_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output rfp_pkg::t_result o_result
);
    import rfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* sv/response_frame_parser_core.sv */
// Top level of the response frame parser: marker registers, phase machine, result register.
//
//  Channel   Direction  Beat contents
//  i_rx      in         rx_byte, expected_length
//  o_res     out        kind, value, data_index, frame_end
//  i_cfg_*   in         register index and byte written, no handshake
//
// Each byte is classified in the cycle it is accepted and appears on o_res the
// next cycle; one beat can be taken every cycle unless a result is held and
// o_res.ready is low. The result register is the only buffer: i_rx.ready is low
// only while a result is held and o_res.ready is low. Reset clears the phase,
// the payload length and count, and all three markers to zero.
module response_frame_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rfp_in_if.sink                        i_rx,
    rfp_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [rfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rfp_pkg::BYTE_W-1:0]    i_cfg_data
);
    import rfp_pkg::*;

    t_markers markers;
    t_result  parse_result;
    t_result  held_result;
    logic     in_ready;
    logic     accept;

    assign accept     = i_rx.valid && in_ready;
    assign i_rx.ready = in_ready;

    rfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_markers  (markers)
    );

    rfp_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx.rx_byte),
        .i_expected_length (i_rx.expected_length),
        .i_markers         (markers),
        .o_result          (parse_result)
    );

    rfp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx.valid),
        .o_ready  (in_ready),
        .i_result (parse_result),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (held_result)
    );

    assign o_res.kind       = held_result.kind;
    assign o_res.value      = held_result.value;
    assign o_res.data_index = held_result.data_index;
    assign o_res.frame_end  = held_result.frame_end;

    // A parsed beat never reports the hunting code.
    a_no_hunt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.kind != KIND_HUNT))
        else $error("result beat carries the hunting code");

    // Only aborted or completed frames raise the frame end flag.
    a_frame_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_end) |->
            (o_res.kind == KIND_BAD_START || o_res.kind == KIND_BAD_END ||
             o_res.kind == KIND_FRAME_OK))
        else $error("frame end flag on a beat that does not close a frame");

    // A payload position is only ever reported on a data beat.
    a_index_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data_index != '0) |-> (o_res.kind == KIND_DATA))
        else $error("non-zero payload index on a beat that is not data");

    // A completed frame always closes on the configured end marker.
    a_frame_ok_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_FRAME_OK) |->
            (o_res.value == markers.end_marker && o_res.frame_end))
        else $error("frame reported complete on a byte other than the end marker");

endmodule
